// ===== hdl/mp3_pkg.sv =====
// shared types and constants for the 3x3 int8 max pooling block
`default_nettype none

package mp3_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int PIX_W     = 8;
	localparam int IDX_W     = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_LIMIT = 1024;

	// clipped windows start from this value, so a lone -128 reads as -127
	localparam logic signed [PIX_W-1:0] PIX_FLOOR = -8'sd127;

	localparam logic [CFG_W-1:0] RST_IN_WIDTH   = 11'd1024;
	localparam logic [CFG_W-1:0] RST_IN_HEIGHT  = 11'd1024;
	localparam logic [2:0]       RST_STRIDE     = 3'd1;
	localparam logic [1:0]       RST_PAD        = 2'd0;
	localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 11'd1022;
	localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 11'd1022;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_WIDTH   = 3'd0,
		CFG_IN_HEIGHT  = 3'd1,
		CFG_STRIDE     = 3'd2,
		CFG_PAD        = 3'd3,
		CFG_OUT_WIDTH  = 3'd4,
		CFG_OUT_HEIGHT = 3'd5
	} cfg_reg_t;

	// one window candidate along one axis
	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] idx;
		logic [1:0]       ext;
	} slot_t;

	function automatic logic signed [PIX_W-1:0] smax(
		input logic signed [PIX_W-1:0] a,
		input logic signed [PIX_W-1:0] b
	);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mp3_line.sv =====
// two-row line store: one entry per column holds the pixels of the two rows above
`default_nettype none

module mp3_line import mp3_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
	input  wire logic                      wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  wire logic [2*PIX_W-1:0]        wr_data,
	output logic      [2*PIX_W-1:0]        rd_data
);

	logic [2*PIX_W-1:0] mem [DEPTH];
	logic [2*PIX_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// forward the write of the same edge when a one-column row hits the same entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== hdl/mp3_axis.sv =====
// window origin decode along one axis: divide by stride, then check the three candidates
`default_nettype none

module mp3_axis import mp3_pkg::*; #(
	parameter int PW = 10
) (
	input  wire logic             clk,
	input  wire logic             load,
	input  wire logic [PW-1:0]    pos,
	input  wire logic             is_last,
	input  wire logic [2:0]       st,
	input  wire logic [1:0]       pd,
	input  wire logic [CFG_W-1:0] limit,
	output slot_t                 slot [3]
);

	localparam int UW    = PW + 1;
	localparam int S3    = UW + 1;
	localparam int MUL3  = ((1 << S3) + 2) / 3;
	localparam int LW    = (UW > CFG_W) ? UW : CFG_W;

	logic [UW-1:0]    u;
	logic [UW-1:0]    q;
	logic [UW-1:0]    q3;
	logic [UW-1:0]    diff3;
	logic [UW+S3-1:0] prod;
	logic [1:0]       rem;
	logic [1:0]       psat;

	logic [UW-1:0]    q_s2;
	logic [1:0]       rem_s2;
	logic             last_s2;
	logic [1:0]       psat_s2;

	// s1: split pos + pad into quotient and remainder by the stride
	always_comb begin
		u     = UW'(pos) + UW'(pd);
		prod  = (UW+S3)'(u) * (UW+S3)'(MUL3);
		q3    = prod[S3 +: UW];
		diff3 = u - {q3[UW-2:0], 1'b0} - q3;
		psat  = (pos >= PW'(2)) ? 2'd2 : pos[1:0];
		case (st)
			3'd2: begin
				q   = u >> 1;
				rem = {1'b0, u[0]};
			end
			3'd3: begin
				q   = q3;
				rem = diff3[1:0];
			end
			3'd4: begin
				q   = u >> 2;
				rem = u[1:0];
			end
			default: begin
				q   = u;
				rem = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q_s2    <= q;
			rem_s2  <= rem;
			last_s2 <= is_last;
			psat_s2 <= psat;
		end
	end

	// s2: candidate k starts at pos - 2 + k; extra candidates only at the last position
	always_comb begin
		logic signed [3:0] x;
		logic signed [3:0] stv;
		logic        [UW:0] qq;
		logic        [1:0]  lim;
		stv = $signed({1'b0, st});
		for (int k = 0; k < 3; k++) begin
			x  = $signed({2'b00, rem_s2}) + $signed(4'(k)) - 4'sd2;
			qq = {1'b0, q_s2};
			if (x[3]) begin
				x  = x + stv;
				qq = qq - (UW+1)'(1);
			end
			if (x[3]) begin
				x  = x + stv;
				qq = qq - (UW+1)'(1);
			end
			lim = 2'(2 - k);
			slot[k].ok  = ((k == 0) || last_s2) && (x == 4'sd0) && !qq[UW]
				&& (LW'(qq[UW-1:0]) < LW'(limit));
			slot[k].idx = IDX_W'(qq[UW-1:0]);
			slot[k].ext = (psat_s2 < lim) ? psat_s2 : lim;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mp3_emit.sv =====
// column maxima, result sequencer over up to nine windows, and the output register
`default_nettype none

module mp3_emit import mp3_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire logic signed [PIX_W-1:0] px,
	input  wire logic signed [PIX_W-1:0] v2,
	input  wire logic signed [PIX_W-1:0] v3,
	input  wire slot_t                   row_slot [3],
	input  wire slot_t                   col_slot [3],
	output logic                         s2_free,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [PIX_W-1:0]      pooled,
	output logic        [IDX_W-1:0]      out_row,
	output logic        [IDX_W-1:0]      out_col,
	output logic                         last
);

	logic signed [PIX_W-1:0] cm_q [3][3];
	logic                    s2_v_q;
	logic [8:0]              taken_q;
	logic                    out_valid_q;
	logic signed [PIX_W-1:0] pooled_q;
	logic [IDX_W-1:0]        row_q;
	logic [IDX_W-1:0]        col_q;
	logic                    last_q;

	logic [8:0]              pend;
	logic [8:0]              cur;
	logic [1:0]              sa;
	logic [1:0]              sb;
	logic                    found;
	logic                    is_final;
	logic                    out_free;
	logic                    emit;
	logic                    s2_done;
	logic signed [PIX_W-1:0] m;
	logic [1:0]              er;
	logic [1:0]              ec;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				pend[a*3+b] = s2_v_q && row_slot[a].ok && col_slot[b].ok && !taken_q[a*3+b];
			end
		end
		found = 1'b0;
		sa    = 2'd0;
		sb    = 2'd0;
		cur   = '0;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				if (!found && pend[a*3+b]) begin
					found        = 1'b1;
					sa           = 2'(a);
					sb           = 2'(b);
					cur[a*3+b]   = 1'b1;
				end
			end
		end
		is_final = ((pend & ~cur) == 9'd0);
		out_free = !out_valid_q || !out_stall;
		emit     = found && out_free;
		s2_done  = s2_v_q && (!found || (emit && is_final));
		s2_free  = !s2_v_q || s2_done;
	end

	// er rows above and ec columns left of the current pixel take part
	always_comb begin
		er = row_slot[sa].ext;
		ec = col_slot[sb].ext;
		m  = cm_q[0][er];
		if (ec != 2'd0) begin
			m = smax(m, cm_q[1][er]);
		end
		if (ec == 2'd2) begin
			m = smax(m, cm_q[2][er]);
		end
		if (!((er == 2'd2) && (ec == 2'd2))) begin
			m = smax(m, PIX_FLOOR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q      <= 1'b0;
			taken_q     <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				for (int e = 0; e < 3; e++) begin
					cm_q[j][e] <= PIX_FLOOR;
				end
			end
		end else begin
			if (load) begin
				s2_v_q  <= 1'b1;
				taken_q <= '0;
				cm_q[2] <= cm_q[1];
				cm_q[1] <= cm_q[0];
				cm_q[0][0] <= px;
				cm_q[0][1] <= v2;
				cm_q[0][2] <= v3;
			end else if (s2_done) begin
				s2_v_q <= 1'b0;
			end else if (emit) begin
				taken_q <= taken_q | cur;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pooled_q <= m;
			row_q    <= row_slot[sa].idx;
			col_q    <= col_slot[sb].idx;
			last_q   <= is_final;
		end
	end

	assign out_valid = out_valid_q;
	assign pooled    = pooled_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== hdl/max_pool_3x3_int8.sv =====
// top level of the streaming 3x3 int8 max pooling block
//
//   channel   dir   handshake               payload
//   input     in    in_valid / in_stall     pixel
//   output    out   out_valid / out_stall   pooled, out_row, out_col, last
//   config    in    cfg_wr_en               cfg_index, cfg_data
//
// one pixel per cycle when each pixel closes at most one window; a pixel at the
// end of a row or plane that closes n windows holds the result sequencer until
// all n are out, one result per cycle unless the output stalls, and stalls the
// input until the last. out_valid follows the line store read at the transfer,
// the window decode and the output register. no clearing pass after reset: the
// line store is only used at rows already written. a stalled output holds the
// sequencer and the stall reaches the input through the two pipeline stages.
`default_nettype none

module max_pool_3x3_int8 import mp3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [PIX_W-1:0] pixel,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [PIX_W-1:0]      pooled,
	output logic        [IDX_W-1:0]      out_row,
	output logic        [IDX_W-1:0]      out_col,
	output logic                         last
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WEW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int HEW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

	logic [CFG_W-1:0] in_width_q;
	logic [CFG_W-1:0] in_height_q;
	logic [2:0]       stride_q;
	logic [1:0]       pad_q;
	logic [CFG_W-1:0] out_width_q;
	logic [CFG_W-1:0] out_height_q;

	logic [WEW-1:0]   w_eff;
	logic [HEW-1:0]   h_eff;
	logic [2:0]       st_eff;
	logic [1:0]       pd_eff;
	logic [CFG_W-1:0] ow_eff;
	logic [CFG_W-1:0] oh_eff;

	logic [CW-1:0]    c_q;
	logic [RW-1:0]    r_q;
	logic             c_wrap;
	logic [CW-1:0]    c0;
	logic [HEW-1:0]   r1;
	logic [RW-1:0]    r0;
	logic [WEW-1:0]   c_inc;
	logic [HEW-1:0]   r_inc;
	logic             c_end;
	logic             r_end;
	logic [CW-1:0]    c_next;
	logic [RW-1:0]    r_next;

	logic                    acc;
	logic                    s1_v_q;
	logic                    s1_go;
	logic                    s2_free;
	logic signed [PIX_W-1:0] px_s1;
	logic [CW-1:0]           c_s1;
	logic [RW-1:0]           r_s1;
	logic                    lastc_s1;
	logic                    lastr_s1;

	logic [2*PIX_W-1:0]      rd_data;
	logic signed [PIX_W-1:0] above1;
	logic signed [PIX_W-1:0] above2;
	logic signed [PIX_W-1:0] v2;
	logic signed [PIX_W-1:0] v3;

	slot_t row_slot [3];
	slot_t col_slot [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= RST_IN_WIDTH;
			in_height_q  <= RST_IN_HEIGHT;
			stride_q     <= RST_STRIDE;
			pad_q        <= RST_PAD;
			out_width_q  <= RST_OUT_WIDTH;
			out_height_q <= RST_OUT_HEIGHT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IN_WIDTH:   in_width_q   <= cfg_data;
				CFG_IN_HEIGHT:  in_height_q  <= cfg_data;
				CFG_STRIDE:     stride_q     <= cfg_data[2:0];
				CFG_PAD:        pad_q        <= cfg_data[1:0];
				CFG_OUT_WIDTH:  out_width_q  <= cfg_data;
				CFG_OUT_HEIGHT: out_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective settings: clamp raw register values into their working ranges
	always_comb begin
		if (in_width_q == '0) begin
			w_eff = WEW'(1);
		end else if (WEW'(in_width_q) > WEW'(MAX_WIDTH)) begin
			w_eff = WEW'(MAX_WIDTH);
		end else begin
			w_eff = WEW'(in_width_q);
		end
		if (in_height_q == '0) begin
			h_eff = HEW'(1);
		end else if (HEW'(in_height_q) > HEW'(MAX_HEIGHT)) begin
			h_eff = HEW'(MAX_HEIGHT);
		end else begin
			h_eff = HEW'(in_height_q);
		end
		if (stride_q == 3'd0) begin
			st_eff = 3'd1;
		end else if (stride_q > 3'd4) begin
			st_eff = 3'd4;
		end else begin
			st_eff = stride_q;
		end
		pd_eff = (pad_q == 2'd3) ? 2'd2 : pad_q;
		ow_eff = (out_width_q > CFG_W'(OUT_LIMIT)) ? CFG_W'(OUT_LIMIT) : out_width_q;
		oh_eff = (out_height_q > CFG_W'(OUT_LIMIT)) ? CFG_W'(OUT_LIMIT) : out_height_q;
	end

	// counters left past a smaller size wrap before the pixel is taken
	always_comb begin
		c_wrap = (WEW'(c_q) >= w_eff);
		c0     = c_wrap ? '0 : c_q;
		r1     = HEW'(r_q) + HEW'(c_wrap);
		r0     = (r1 >= h_eff) ? '0 : r1[RW-1:0];
		c_inc  = WEW'(c0) + WEW'(1);
		r_inc  = HEW'(r0) + HEW'(1);
		c_end  = (c_inc >= w_eff);
		r_end  = (r_inc >= h_eff);
		c_next = c_end ? '0 : c_inc[CW-1:0];
		if (c_end) begin
			r_next = r_end ? '0 : r_inc[RW-1:0];
		end else begin
			r_next = r0;
		end
	end

	assign s1_go    = s1_v_q && s2_free;
	assign in_stall = s1_v_q && !s2_free;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q    <= '0;
			r_q    <= '0;
			s1_v_q <= 1'b0;
		end else begin
			if (acc) begin
				c_q    <= c_next;
				r_q    <= r_next;
				s1_v_q <= 1'b1;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1    <= pixel;
			c_s1     <= c0;
			r_s1     <= r0;
			lastc_s1 <= c_end;
			lastr_s1 <= r_end;
		end
	end

	mp3_line #(
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (c0),
		.wr_en   (s1_go),
		.wr_addr (c_s1),
		.wr_data ({px_s1, above1}),
		.rd_data (rd_data)
	);

	// vertical maxima over one, two and three rows at this column
	always_comb begin
		above1 = $signed(rd_data[2*PIX_W-1:PIX_W]);
		above2 = $signed(rd_data[PIX_W-1:0]);
		v2     = smax(px_s1, above1);
		v3     = smax(v2, above2);
	end

	mp3_axis #(
		.PW (RW)
	) u_row_axis (
		.clk     (clk),
		.load    (s1_go),
		.pos     (r_s1),
		.is_last (lastr_s1),
		.st      (st_eff),
		.pd      (pd_eff),
		.limit   (oh_eff),
		.slot    (row_slot)
	);

	mp3_axis #(
		.PW (CW)
	) u_col_axis (
		.clk     (clk),
		.load    (s1_go),
		.pos     (c_s1),
		.is_last (lastc_s1),
		.st      (st_eff),
		.pd      (pd_eff),
		.limit   (ow_eff),
		.slot    (col_slot)
	);

	mp3_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_go),
		.px        (px_s1),
		.v2        (v2),
		.v3        (v3),
		.row_slot  (row_slot),
		.col_slot  (col_slot),
		.s2_free   (s2_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pooled    (pooled),
		.out_row   (out_row),
		.out_col   (out_col),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== test/max_pool_3x3_int8_tb.sv =====
// self-checking testbench for the streaming 3x3 int8 max pooling block
`default_nettype none

module max_pool_3x3_int8_tb;
	import mp3_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [PIX_W-1:0] pooled;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic                    last;
	} pool_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [PIX_W-1:0] pixel = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [PIX_W-1:0] pooled;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic                    last;

	max_pool_3x3_int8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pooled(pooled),
		.out_row(out_row),
		.out_col(out_col),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pooling state mirrored from the block
	logic [CFG_W-1:0]        in_width_r, in_height_r, out_width_r, out_height_r;
	logic [2:0]              stride_r;
	logic [1:0]              pad_r;
	logic signed [PIX_W-1:0] line_buf [2*MAX_WIDTH_DEF];
	int                      col_max [3][3];
	int                      row_cnt, col_cnt;

	logic signed [PIX_W-1:0] pending_pixels [$];
	pool_result_t            window_max_q [$];
	pool_result_t            head_res;
	int unsigned             err_cnt = 0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_req = 1'b0;
	bit          hold_seen = 1'b0;
	int unsigned hold_left = 0;

	function automatic int clampi(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic int imax(int a, int b);
		return (a > b) ? a : b;
	endfunction

	// windows along one axis whose last in-image position is pos
	function automatic void axis_windows(input int pos, input int lst, input int st,
			input int pd, input int lim, output int cnt, output int idx[3],
			output int org[3], output bit full[3]);
		int s0, t;
		cnt = 0;
		idx = '{0, 0, 0};
		org = '{0, 0, 0};
		full = '{0, 0, 0};
		for (int k = 0; k <= ((pos == lst) ? 2 : 0); k++) begin
			s0 = pos - 2 + k;
			t = s0 + pd;
			if (s0 >= -2 && t >= 0 && t % st == 0 && t / st < lim) begin
				idx[cnt] = t / st;
				org[cnt] = (s0 < 0) ? 0 : s0;
				full[cnt] = (s0 >= 0) && (s0 + 3 <= lst + 1);
				cnt++;
			end
		end
	endfunction

	function automatic void pool_window_step(logic signed [PIX_W-1:0] px);
		int w, h, st, pd, ow, oh, r, c, cur, prv, v2, v3, nr, nc, er, ec, m, pv;
		int ri[3], rs[3], ci[3], cs[3];
		bit rf[3], cf[3];
		pool_result_t res;
		w = clampi(in_width_r, 1, MAX_WIDTH_DEF);
		h = clampi(in_height_r, 1, MAX_HEIGHT_DEF);
		st = clampi(stride_r, 1, 4);
		pd = clampi(pad_r, 0, 2);
		ow = clampi(out_width_r, 0, OUT_LIMIT);
		oh = clampi(out_height_r, 0, OUT_LIMIT);

		// counters left past shrunken bounds wrap first
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= h)
			row_cnt = 0;
		r = row_cnt;
		c = col_cnt;

		pv = px;
		cur = (r % 2) * MAX_WIDTH_DEF + c;
		prv = ((r + 1) % 2) * MAX_WIDTH_DEF + c;
		v2 = imax(pv, line_buf[prv]);
		v3 = imax(v2, line_buf[cur]);
		line_buf[cur] = px;

		for (int e = 0; e < 3; e++) begin
			col_max[2][e] = col_max[1][e];
			col_max[1][e] = col_max[0][e];
		end
		col_max[0][0] = pv;
		col_max[0][1] = v2;
		col_max[0][2] = v3;

		axis_windows(r, h - 1, st, pd, oh, nr, ri, rs, rf);
		axis_windows(c, w - 1, st, pd, ow, nc, ci, cs, cf);
		for (int a = 0; a < nr; a++) begin
			er = r - rs[a];
			for (int b = 0; b < nc; b++) begin
				ec = c - cs[b];
				// clipped windows start from the floor, full ones from the window itself
				m = (rf[a] && cf[b]) ? col_max[0][er] : int'(PIX_FLOOR);
				for (int j = 0; j <= ec; j++)
					m = imax(m, col_max[j][er]);
				res.pooled = m[PIX_W-1:0];
				res.row = ri[a][IDX_W-1:0];
				res.col = ci[b][IDX_W-1:0];
				res.last = (a == nr - 1) && (b == nc - 1);
				window_max_q.push_back(res);
			end
		end

		col_cnt++;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= h)
				row_cnt = 0;
		end
	endfunction

	function automatic void check_field(string name, logic signed [10:0] want,
			logic signed [10:0] got);
		if (got !== want) begin
			err_cnt++;
			if (err_cnt <= 50)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// input driver
	always @(posedge clk) begin
		if (!arst_n)
			in_valid <= 1'b0;
		else if (!in_valid || !in_stall) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				pixel <= pending_pixels.pop_front();
			end else
				in_valid <= 1'b0;
		end
	end

	// output stall, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = 300;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// monitor: check the output transfer, then predict from the input transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (window_max_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 50)
						$display("%0t: unexpected result, expected none, actual %0d row %0d col %0d",
							$time, pooled, out_row, out_col);
				end else begin
					head_res = window_max_q.pop_front();
					check_field("pooled", head_res.pooled, pooled);
					check_field("out_row", head_res.row, out_row);
					check_field("out_col", head_res.col, out_col);
					check_field("last", head_res.last, last);
				end
			end
			if (in_valid && !in_stall)
				pool_window_step(pixel);
		end
	end

	task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	task automatic feed(logic signed [PIX_W-1:0] p);
		pending_pixels.push_back(p);
	endtask

	function automatic logic signed [PIX_W-1:0] rand_pixel();
		case ($urandom_range(7))
			0: return -8'sd128;
			1: return 8'sd127;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	// wait until every pixel is taken and every result is back, then let the pipe drain
	// sampled at the falling edge so the rising-edge updates have all landed
	task automatic settle();
		@(negedge clk);
		while (pending_pixels.size() != 0 || in_valid || window_max_q.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_IN_WIDTH:   in_width_r = val[CFG_W-1:0];
			CFG_IN_HEIGHT:  in_height_r = val[CFG_W-1:0];
			CFG_STRIDE:     stride_r = val[2:0];
			CFG_PAD:        pad_r = val[1:0];
			CFG_OUT_WIDTH:  out_width_r = val[CFG_W-1:0];
			CFG_OUT_HEIGHT: out_height_r = val[CFG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(int unsigned w, int unsigned h, int unsigned st,
			int unsigned pd, int unsigned ow, int unsigned oh);
		settle();
		write_reg(CFG_IN_WIDTH, w);
		write_reg(CFG_IN_HEIGHT, h);
		write_reg(CFG_STRIDE, st);
		write_reg(CFG_PAD, pd);
		write_reg(CFG_OUT_WIDTH, ow);
		write_reg(CFG_OUT_HEIGHT, oh);
	endtask

	initial begin
		#10ms;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int unsigned w_raw, h_raw, ow_raw, oh_raw, npix, sent;
		in_width_r = RST_IN_WIDTH;
		in_height_r = RST_IN_HEIGHT;
		stride_r = RST_STRIDE;
		pad_r = RST_PAD;
		out_width_r = RST_OUT_WIDTH;
		out_height_r = RST_OUT_HEIGHT;
		foreach (line_buf[i])
			line_buf[i] = '0;
		foreach (col_max[i, j])
			col_max[i][j] = PIX_FLOOR;
		row_cnt = 0;
		col_cnt = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		set_idle(22, 47);

		// zero sizes and stride act as one: every pixel is a 1x1 plane with nine clipped windows
		configure(0, 0, 0, 2, 3, 3);
		feed(-8'sd128);
		feed(8'sd127);
		feed(-8'sd1);
		feed(8'sd0);
		// one full window keeps a plain -128
		configure(3, 3, 1, 0, 1, 1);
		repeat (9) feed(-8'sd128);
		// zero output width gives nothing
		configure(2, 2, 2, 1, 0, 2);
		repeat (4) feed(rand_pixel());
		// shrink the plane part way through
		configure(3, 4, 1, 1, 4, 4);
		repeat (4) feed(rand_pixel());
		settle();
		write_reg(CFG_IN_WIDTH, 1);
		feed(rand_pixel());
		settle();
		write_reg(CFG_IN_HEIGHT, 2);
		repeat (2) feed(rand_pixel());

		for (int seg = 0; seg < 3; seg++) begin
			if (seg == 0)
				set_idle(22, 47);
			else if (seg == 1)
				set_idle(47, 22);
			else
				set_idle(0, 0);
			sent = 0;
			while (sent < 35) begin
				w_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
				h_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
				case ($urandom_range(9))
					0: ow_raw = 0;
					1: ow_raw = 2047;
					2: ow_raw = $urandom_range(1025, 2046);
					default: ow_raw = $urandom_range(1, 6);
				endcase
				case ($urandom_range(9))
					0: oh_raw = 0;
					1: oh_raw = 2047;
					default: oh_raw = $urandom_range(1, 6);
				endcase
				configure(w_raw, h_raw, $urandom_range(0, 7), $urandom_range(0, 3),
					ow_raw, oh_raw);
				// whole planes only, so a later width change never reads stale line data
				npix = $urandom_range(1, 2) * clampi(w_raw, 1, MAX_WIDTH_DEF)
					* clampi(h_raw, 1, MAX_HEIGHT_DEF);
				repeat (npix) feed(rand_pixel());
				sent += npix;
			end
		end

		// start of the widest row, with the receiver holding off long enough to back up the input
		configure(2047, 1, 1, 2, 2047, 2047);
		hold_req <= ~hold_req;
		repeat (32) feed(rand_pixel());
		// one column of the tallest plane, from the next row; the sender waits for all results
		configure(1, 2047, 1, 2, 1, 2047);
		repeat (16) feed(rand_pixel());
		settle();
		repeat (16) feed(rand_pixel());

		settle();
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ===== max_pool_3x3_int8.f =====
hdl/mp3_pkg.sv
hdl/mp3_line.sv
hdl/mp3_axis.sv
hdl/mp3_emit.sv
hdl/max_pool_3x3_int8.sv
test/max_pool_3x3_int8_tb.sv
